FILE: hw/rtl/leb_pkg.sv
// Shared types and constants for the line edit buffer.
// No dependencies; every other file of the block refers to this package by scoped names.
package leb_pkg;

   localparam int unsigned MAX_LEN = 32;
   localparam int unsigned LEN_W   = $clog2(MAX_LEN + 1);
   localparam int unsigned POS_W   = $clog2(MAX_LEN);
   localparam int unsigned CHAR_W  = 8;
   localparam int unsigned CMD_W   = 4;
   localparam int unsigned RPOS_W  = 5;

   localparam int unsigned REQ_TDATA_W = 24;
   localparam int unsigned RSP_TDATA_W = 24;

   localparam logic [CHAR_W-1:0] KEY_CR          = 8'd13;
   localparam logic [CHAR_W-1:0] FIRST_PRINTABLE = 8'd32;
   localparam logic [CHAR_W-1:0] FIRST_HIGH      = 8'd128;

   typedef enum logic [CMD_W-1:0] {
      CMD_CHAR      = 4'd0,
      CMD_BACKSPACE = 4'd1,
      CMD_DELETE    = 4'd2,
      CMD_LEFT      = 4'd3,
      CMD_RIGHT     = 4'd4,
      CMD_HOME      = 4'd5,
      CMD_END       = 4'd6,
      CMD_CLEAR     = 4'd7,
      CMD_TOGGLE    = 4'd8,
      CMD_QUERY     = 4'd9
   } cmd_type;

   typedef enum logic [1:0] {
      EDIT_NONE      = 2'd0,
      EDIT_INSERT    = 2'd1,
      EDIT_OVERWRITE = 2'd2,
      EDIT_REMOVE    = 2'd3
   } edit_op_type;

   // One change to the character array, decided by the edit control.
   typedef struct packed {
      edit_op_type       op;
      logic [POS_W-1:0]  pos;
      logic [CHAR_W-1:0] ch;
   } edit_type;

   // Packed with the command in the lowest bits, matching the req_tdata layout.
   typedef struct packed {
      logic [RPOS_W-1:0] read_pos;
      logic [CHAR_W-1:0] key_char;
      logic [CMD_W-1:0]  cmd;
   } req_type;

   typedef struct packed {
      logic [LEN_W-1:0] cursor;
      logic [LEN_W-1:0] length;
      logic             overwrite;
   } line_state_type;

endpackage

FILE: hw/rtl/leb_edit_ctrl.sv
// Decodes one key event against the current cursor, length and mode.
// Depends on leb_pkg; purely combinational.
module leb_edit_ctrl (
   input  leb_pkg::req_type        req,
   input  leb_pkg::line_state_type cur_state,
   output leb_pkg::line_state_type next_state,
   output leb_pkg::edit_type       edit,
   output logic                    error,
   output logic                    enter
);

   logic printable;
   logic full;

   assign printable = (req.key_char >= leb_pkg::FIRST_PRINTABLE) &&
                      (req.key_char <  leb_pkg::FIRST_HIGH);
   assign full      = (cur_state.length >= leb_pkg::LEN_W'(leb_pkg::MAX_LEN));

   always_comb begin
      next_state = cur_state;
      edit.op    = leb_pkg::EDIT_NONE;
      edit.pos   = cur_state.cursor[leb_pkg::POS_W-1:0];
      edit.ch    = req.key_char;
      error      = 1'b0;
      enter      = 1'b0;

      case (leb_pkg::cmd_type'(req.cmd))
         leb_pkg::CMD_CHAR: begin
            if (req.key_char == leb_pkg::KEY_CR) begin
               enter = 1'b1;
            end else if (printable) begin
               if (cur_state.overwrite && (cur_state.cursor < cur_state.length)) begin
                  edit.op           = leb_pkg::EDIT_OVERWRITE;
                  next_state.cursor = cur_state.cursor + 1'b1;
               end else if (full) begin
                  error = 1'b1;
               end else begin
                  edit.op           = leb_pkg::EDIT_INSERT;
                  next_state.cursor = cur_state.cursor + 1'b1;
                  next_state.length = cur_state.length + 1'b1;
               end
            end
         end
         leb_pkg::CMD_BACKSPACE: begin
            // The cursor never exceeds the length, so the character left of it exists.
            if (cur_state.cursor != '0) begin
               edit.op           = leb_pkg::EDIT_REMOVE;
               edit.pos          = cur_state.cursor[leb_pkg::POS_W-1:0] - 1'b1;
               next_state.cursor = cur_state.cursor - 1'b1;
               next_state.length = cur_state.length - 1'b1;
            end else begin
               error = 1'b1;
            end
         end
         leb_pkg::CMD_DELETE: begin
            if (cur_state.cursor < cur_state.length) begin
               edit.op           = leb_pkg::EDIT_REMOVE;
               next_state.length = cur_state.length - 1'b1;
            end else begin
               error = 1'b1;
            end
         end
         leb_pkg::CMD_LEFT: begin
            if (cur_state.cursor != '0) begin
               next_state.cursor = cur_state.cursor - 1'b1;
            end
         end
         leb_pkg::CMD_RIGHT: begin
            if (cur_state.cursor < cur_state.length) begin
               next_state.cursor = cur_state.cursor + 1'b1;
            end
         end
         leb_pkg::CMD_HOME: begin
            next_state.cursor = '0;
         end
         leb_pkg::CMD_END: begin
            next_state.cursor = cur_state.length;
         end
         leb_pkg::CMD_CLEAR: begin
            next_state.cursor = '0;
            next_state.length = '0;
         end
         leb_pkg::CMD_TOGGLE: begin
            next_state.overwrite = ~cur_state.overwrite;
         end
         default: begin
         end
      endcase
   end

endmodule

FILE: hw/rtl/leb_line_store.sv
// Character array of the line, one register per column, shifting all columns in parallel.
// Depends on leb_pkg; the read port returns the content as it will be after this edit.
module leb_line_store (
   input  logic                         clock,
   input  logic                         commit,
   input  leb_pkg::edit_type            edit,
   input  logic [leb_pkg::POS_W-1:0]    rd_pos,
   output logic [leb_pkg::CHAR_W-1:0]   rd_data
);

   logic [leb_pkg::CHAR_W-1:0] store_ff [leb_pkg::MAX_LEN];
   logic [leb_pkg::CHAR_W-1:0] store_in [leb_pkg::MAX_LEN];

   for (genvar i = 0; i < leb_pkg::MAX_LEN; i++) begin : g_col
      localparam int unsigned PREV = (i == 0) ? 0 : i - 1;
      localparam int unsigned NEXT = (i == leb_pkg::MAX_LEN - 1) ? i : i + 1;
      localparam logic [leb_pkg::POS_W-1:0] COL = leb_pkg::POS_W'(i);

      always_comb begin
         store_in[i] = store_ff[i];
         case (edit.op)
            leb_pkg::EDIT_INSERT: begin
               if (COL == edit.pos) begin
                  store_in[i] = edit.ch;
               end else if (COL > edit.pos) begin
                  store_in[i] = store_ff[PREV];
               end
            end
            leb_pkg::EDIT_OVERWRITE: begin
               if (COL == edit.pos) begin
                  store_in[i] = edit.ch;
               end
            end
            leb_pkg::EDIT_REMOVE: begin
               if (COL >= edit.pos) begin
                  store_in[i] = store_ff[NEXT];
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         store_ff <= store_in;
      end
   end

   assign rd_data = store_in[rd_pos];

endmodule

FILE: hw/rtl/line_edit_buffer_core.sv
// Line edit buffer: top level with the input register, line state and result register.
// Depends on leb_pkg, leb_edit_ctrl and leb_line_store.
//
// The block keeps one line of up to 32 characters with a cursor and an insert or overwrite
// mode, and takes one key event per item on the req stream. Every item gives exactly one
// result item on the rsp stream carrying the error and enter flags, the cursor, the length,
// the mode and the character at the requested position as it stands after the edit
// (zero at or beyond the length). An item accepted at a clock edge sits in the input
// register and is decoded there; it is applied to the line and its result loaded into the
// result register together, once that register is empty or being emptied. One item is
// taken every cycle while the result stream keeps up: the combinational edit path (decode,
// parallel shift of all 32 column registers and the read multiplexer) allows that rate, and
// the input register keeps accepting while a result still waits to be taken, stopping only
// when both registers are full. Control codes and codes of 128 and above are ignored,
// a carriage return only raises the enter flag, and the line content after reset is
// undefined until typed; it is never reported because the length starts at zero.
module line_edit_buffer_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [3:0] cmd, [11:4] key_char, [16:12] read_pos, [23:17] zero
   input  logic [leb_pkg::REQ_TDATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] error, [1] enter_pressed, [7:2] cursor_out, [13:8] length_out,
   // [14] overwrite_out, [22:15] read_char, [23] zero
   output logic [leb_pkg::RSP_TDATA_W-1:0]     rsp_tdata
);

   localparam int unsigned REQ_USED_W = $bits(leb_pkg::req_type);
   localparam int unsigned RSP_USED_W = 2 + 2 * leb_pkg::LEN_W + 1 + leb_pkg::CHAR_W;

   // Input register: holds one accepted item until the result register can take it.
   logic                    in_valid_ff, in_valid_in;
   leb_pkg::req_type        req_ff, req_in;

   // Line state other than the characters themselves.
   leb_pkg::line_state_type state_ff, state_in;

   // Result register.
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_USED_W-1:0]   rsp_data_ff, rsp_data_in;

   logic                    req_accept;
   logic                    advance;
   leb_pkg::edit_type       edit;
   logic                    edit_error;
   logic                    edit_enter;
   logic [leb_pkg::CHAR_W-1:0] store_data;
   logic [leb_pkg::CHAR_W-1:0] read_char;

   // An item moves into the result register when that register is empty or being emptied.
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      req_in = req_ff;
      if (req_accept) begin
         req_in = req_tdata[REQ_USED_W-1:0];
      end
   end

   always_comb begin
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   leb_edit_ctrl u_edit_ctrl (
      .req        (req_ff),
      .cur_state  (state_ff),
      .next_state (state_in),
      .edit       (edit),
      .error      (edit_error),
      .enter      (edit_enter)
   );

   leb_line_store u_line_store (
      .clock   (clock),
      .commit  (advance),
      .edit    (edit),
      .rd_pos  (req_ff.read_pos),
      .rd_data (store_data)
   );

   // Columns at or beyond the new length hold stale characters and read as zero.
   assign read_char = ({1'b0, req_ff.read_pos} < state_in.length) ? store_data : '0;

   assign rsp_data_in = {read_char, state_in.overwrite, state_in.length, state_in.cursor,
                         edit_enter, edit_error};

   always_comb begin
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(leb_pkg::RSP_TDATA_W - RSP_USED_W){1'b0}}, rsp_data_ff};

endmodule

FILE: test/testbench.sv
// Self-checking testbench for line_edit_buffer_core: key events in, line views out.
// Depends on leb_pkg and the line_edit_buffer_core RTL. A shadow copy of the line
// predicts every result item, and random idling on both streams exercises back-pressure.
module testbench;

   localparam int unsigned RANDOM_KEYS = 800;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned HOLD_START  = 300;
   localparam int unsigned HOLD_CYCLES = 150;
   localparam int unsigned DRAIN_CYCLES = 8;

   // One result item, unpacked into its fields.
   typedef struct packed {
      logic                       error;
      logic                       enter;
      logic [leb_pkg::LEN_W-1:0]  cursor;
      logic [leb_pkg::LEN_W-1:0]  length;
      logic                       overwrite;
      logic [leb_pkg::CHAR_W-1:0] read_char;
   } line_view_type;

   // Shadow copy of the line. Each accepted key event updates it and queues the view
   // that the block should report; each result item is checked against the oldest one.
   class line_shadow;
      logic [leb_pkg::CHAR_W-1:0] chars [leb_pkg::MAX_LEN];
      logic [leb_pkg::LEN_W-1:0]  cursor;
      logic [leb_pkg::LEN_W-1:0]  length;
      logic                       overwrite;
      line_view_type              pending_views [$];
      int                         mismatches;

      function new();
         foreach (chars[i]) chars[i] = '0;
         cursor     = '0;
         length     = '0;
         overwrite  = 1'b0;
         mismatches = 0;
      endfunction

      // Close the gap at pos; the cursor stays where it is.
      function void remove_at(int pos);
         for (int i = pos; i + 1 < length; i++) chars[i] = chars[i + 1];
         length--;
      endfunction

      function bit delete_at_cursor();
         if (cursor < length) begin
            remove_at(cursor);
            return 1'b0;
         end
         return 1'b1;
      endfunction

      function bit type_char(logic [leb_pkg::CHAR_W-1:0] ch);
         if (overwrite && cursor < length) begin
            chars[cursor] = ch;
            cursor++;
            return 1'b0;
         end
         if (length >= leb_pkg::MAX_LEN) return 1'b1;
         for (int i = length; i > cursor; i--) chars[i] = chars[i - 1];
         chars[cursor] = ch;
         length++;
         cursor++;
         return 1'b0;
      endfunction

      function void apply_key(leb_pkg::req_type key);
         line_view_type view;
         logic          err;
         logic          enter;
         err   = 1'b0;
         enter = 1'b0;
         case (key.cmd)
            leb_pkg::CMD_CHAR: begin
               if (key.key_char == leb_pkg::KEY_CR) enter = 1'b1;
               else if (key.key_char >= leb_pkg::FIRST_PRINTABLE &&
                        key.key_char < leb_pkg::FIRST_HIGH)
                  err = type_char(key.key_char);
            end
            leb_pkg::CMD_BACKSPACE: begin
               if (cursor > 0) begin
                  cursor--;
                  err = delete_at_cursor();
               end else begin
                  err = 1'b1;
               end
            end
            leb_pkg::CMD_DELETE: err = delete_at_cursor();
            leb_pkg::CMD_LEFT:   if (cursor > 0) cursor--;
            leb_pkg::CMD_RIGHT:  if (cursor < length) cursor++;
            leb_pkg::CMD_HOME:   cursor = '0;
            leb_pkg::CMD_END:    cursor = length;
            leb_pkg::CMD_CLEAR: begin
               length = '0;
               cursor = '0;
            end
            leb_pkg::CMD_TOGGLE: overwrite = ~overwrite;
            default: ;
         endcase
         view.error     = err;
         view.enter     = enter;
         view.cursor    = cursor;
         view.length    = length;
         view.overwrite = overwrite;
         view.read_char = (key.read_pos < length) ? chars[key.read_pos] : '0;
         pending_views.push_back(view);
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void check_view(logic [leb_pkg::RSP_TDATA_W-1:0] word);
         line_view_type got;
         line_view_type want;
         got.error     = word[0];
         got.enter     = word[1];
         got.cursor    = word[7:2];
         got.length    = word[13:8];
         got.overwrite = word[14];
         got.read_char = word[22:15];
         if (pending_views.size() == 0) begin
            $display("%0t: unexpected result item, expected none, actual %h", $time, word);
            mismatches++;
            return;
         end
         want = pending_views.pop_front();
         compare_field("error", want.error, got.error);
         compare_field("enter_pressed", want.enter, got.enter);
         compare_field("cursor_out", want.cursor, got.cursor);
         compare_field("length_out", want.length, got.length);
         compare_field("overwrite_out", want.overwrite, got.overwrite);
         compare_field("read_char", want.read_char, got.read_char);
      endfunction
   endclass

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [leb_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [leb_pkg::RSP_TDATA_W-1:0] rsp_tdata;

   line_shadow  shadow = new();
   int unsigned keys_sent = 0;
   int unsigned cycle_count = 0;
   logic        hold_off = 1'b0;
   int          source_calm = 0;
   int          sink_calm = 0;

   line_edit_buffer_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Idle cycles before the next item, drawn at random, with occasional calm stretches
   // in which the side never idles.
   function automatic int pick_gap(ref int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) calm = $urandom_range(20, 60);
      return $urandom_range(0, 13);
   endfunction

   // Offer one key event and hold it until the block takes it.
   task automatic send_key(logic [leb_pkg::CMD_W-1:0] cmd, logic [leb_pkg::CHAR_W-1:0] key,
                           logic [leb_pkg::RPOS_W-1:0] pos);
      leb_pkg::req_type item;
      int               gap;
      item.cmd      = cmd;
      item.key_char = key;
      item.read_pos = pos;
      gap = pick_gap(source_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {{(leb_pkg::REQ_TDATA_W - leb_pkg::CMD_W - leb_pkg::CHAR_W -
                       leb_pkg::RPOS_W){1'b0}}, pos, key, cmd};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      shadow.apply_key(item);
      keys_sent++;
   endtask

   function automatic logic [leb_pkg::RPOS_W-1:0] any_pos();
      return leb_pkg::RPOS_W'($urandom_range(0, leb_pkg::MAX_LEN - 1));
   endfunction

   function automatic logic [leb_pkg::CHAR_W-1:0] any_char();
      return leb_pkg::CHAR_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [leb_pkg::CHAR_W-1:0] printable();
      return leb_pkg::CHAR_W'($urandom_range(leb_pkg::FIRST_PRINTABLE,
                                             leb_pkg::FIRST_HIGH - 1));
   endfunction

   // Mostly typing, so that the line fills up and the full-line error is reached.
   task automatic typing_run();
      int n;
      int pick;
      n = $urandom_range(20, 40);
      repeat (n) begin
         pick = $urandom_range(0, 15);
         if (pick == 0) send_key(leb_pkg::CMD_HOME, any_char(), any_pos());
         else if (pick == 1) send_key(leb_pkg::CMD_LEFT, any_char(), any_pos());
         else if (pick == 2) send_key(leb_pkg::CMD_TOGGLE, any_char(), any_pos());
         else send_key(leb_pkg::CMD_CHAR, printable(), any_pos());
      end
   endtask

   // A mix of every editing command.
   task automatic editing_run();
      int n;
      int pick;
      n = $urandom_range(8, 24);
      repeat (n) begin
         pick = $urandom_range(0, 19);
         if (pick < 8) send_key(leb_pkg::CMD_CHAR, printable(), any_pos());
         else send_key(leb_pkg::CMD_W'($urandom_range(leb_pkg::CMD_BACKSPACE,
                                                      leb_pkg::CMD_QUERY)),
                       any_char(), any_pos());
      end
   endtask

   // Any command code, unused ones included, with any character.
   task automatic noise_run();
      int n;
      n = $urandom_range(4, 12);
      repeat (n) send_key(leb_pkg::CMD_W'($urandom_range(0, 15)), any_char(), any_pos());
   endtask

   // Receiver: idles at random per item and during the long hold-off.
   initial begin : result_sink
      int wait_cycles;
      while (reset) @(posedge clock);
      forever begin
         wait_cycles = pick_gap(sink_calm);
         if (wait_cycles > 0 || hold_off) begin
            rsp_tready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
            while (hold_off) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         shadow.check_view(rsp_tdata);
      end
   end

   // Long stall of the result stream while the sender keeps offering items, so that
   // both internal registers fill and the input stalls.
   initial begin : long_hold
      while (keys_sent < HOLD_START) @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TEST FAILED");
      $finish;
   end

   initial begin : stimulus
      int unsigned random_end;
      int          kind;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part: empty-line edges first, then the character classes, then insertion
      // and removal at both ends and overwrite at the start.
      send_key(leb_pkg::CMD_QUERY, 8'd0, 5'd0);
      send_key(leb_pkg::CMD_BACKSPACE, 8'd0, 5'd31);
      send_key(leb_pkg::CMD_DELETE, 8'd255, 5'd0);
      send_key(leb_pkg::CMD_LEFT, 8'd0, 5'd0);
      send_key(leb_pkg::CMD_RIGHT, 8'd0, 5'd0);
      send_key(leb_pkg::CMD_CHAR, leb_pkg::KEY_CR, 5'd0);
      send_key(leb_pkg::CMD_CHAR, 8'd0, 5'd0);
      send_key(leb_pkg::CMD_CHAR, 8'd31, 5'd0);
      send_key(leb_pkg::CMD_CHAR, 8'd128, 5'd0);
      send_key(leb_pkg::CMD_CHAR, 8'd255, 5'd0);
      send_key(leb_pkg::CMD_CHAR, 8'd32, 5'd0);
      send_key(leb_pkg::CMD_CHAR, 8'd127, 5'd1);
      send_key(leb_pkg::CMD_HOME, 8'd0, 5'd0);
      send_key(leb_pkg::CMD_CHAR, 8'h42, 5'd0);
      send_key(leb_pkg::CMD_RIGHT, 8'd0, 5'd2);
      send_key(leb_pkg::CMD_DELETE, 8'd0, 5'd1);
      send_key(leb_pkg::CMD_END, 8'd0, 5'd1);
      send_key(leb_pkg::CMD_TOGGLE, 8'd0, 5'd0);
      send_key(leb_pkg::CMD_CHAR, 8'h55, 5'd2);
      send_key(leb_pkg::CMD_HOME, 8'd0, 5'd0);
      send_key(leb_pkg::CMD_CHAR, 8'h2a, 5'd0);
      send_key(leb_pkg::CMD_BACKSPACE, 8'd0, 5'd0);
      send_key(4'd10, 8'd13, 5'd31);
      send_key(4'd15, 8'd0, 5'd1);
      send_key(leb_pkg::CMD_CLEAR, 8'd0, 5'd0);
      send_key(leb_pkg::CMD_TOGGLE, 8'd0, 5'd0);

      random_end = keys_sent + RANDOM_KEYS;
      while (keys_sent < random_end) begin
         kind = $urandom_range(0, 9);
         if (kind < 4) typing_run();
         else if (kind < 8) editing_run();
         else noise_run();
      end
      req_tvalid <= 1'b0;

      while (shadow.pending_views.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (shadow.mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule

FILE: sim.f
hw/rtl/leb_pkg.sv
hw/rtl/leb_edit_ctrl.sv
hw/rtl/leb_line_store.sv
hw/rtl/line_edit_buffer_core.sv
test/testbench.sv
